FILE: sv/tick_subscriber_dispatch_unit_defines.svh
// Assertion macros for the tick subscriber dispatch unit.
// They expect signals named clk and rst_n in the scope where they are used.
`ifndef TICK_SUBSCRIBER_DISPATCH_UNIT_DEFINES_SVH
`define TICK_SUBSCRIBER_DISPATCH_UNIT_DEFINES_SVH
`ifndef SYNTHESIS
`define TSD_ASSERT(label, prop) \
    label: assert property (@(posedge clk) disable iff (!rst_n) prop) \
        else $error("tsd: property violated");
`define TSD_NEVER(label, expr) \
    label: assert property (@(posedge clk) disable iff (!rst_n) !(expr)) \
        else $error("tsd: forbidden condition seen");
`else
`define TSD_ASSERT(label, prop)
`define TSD_NEVER(label, expr)
`endif
`endif

FILE: sv/tsd_pkg.sv
package tsd_pkg;

    localparam int MAX_SUBS    = 8;
    localparam int HANDLE_BITS = 16;
    localparam int TIME_W      = 32;
    localparam int CMD_W       = 3;
    localparam int STATUS_W    = 2;
    localparam int CFG_W       = 16;
    localparam int CFG_IDX_W   = 1;

    localparam logic [CMD_W-1:0] CMD_REG   = 3'd0;
    localparam logic [CMD_W-1:0] CMD_UNREG = 3'd1;
    localparam logic [CMD_W-1:0] CMD_TICK  = 3'd2;
    localparam logic [CMD_W-1:0] CMD_TIMED = 3'd3;
    localparam logic [CMD_W-1:0] CMD_RESET = 3'd4;

    localparam logic [STATUS_W-1:0] ST_OK      = 2'd0;
    localparam logic [STATUS_W-1:0] ST_FULL    = 2'd1;
    localparam logic [STATUS_W-1:0] ST_MISSING = 2'd2;

    localparam logic [CFG_IDX_W-1:0] CFG_TICK_PERIOD = 1'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_MAX_CATCHUP = 1'd1;

    localparam logic [CFG_W-1:0] PERIOD_RST  = 16'd1;
    localparam logic [CFG_W-1:0] CATCHUP_RST = 16'd1000;

    // Clock update request raised by the sequencer when it accepts an item.
    typedef struct packed {
        logic              go;
        logic              nominal;
        logic              timed;
        logic              clear;
        logic [TIME_W-1:0] wall;
    } tsd_tick_cmd_t;

endpackage

FILE: sv/tsd_in_if.sv
interface tsd_in_if #(
    parameter int HANDLE_BITS = tsd_pkg::HANDLE_BITS
);
    logic                        valid;
    logic                        ready;
    logic [tsd_pkg::CMD_W-1:0]   cmd;
    logic [HANDLE_BITS-1:0]      handle;
    logic [tsd_pkg::TIME_W-1:0]  wall_time;

    modport source (output valid, output cmd, output handle, output wall_time,
                    input ready);
    modport sink (input valid, input cmd, input handle, input wall_time,
                  output ready);
endinterface

FILE: sv/tsd_out_if.sv
interface tsd_out_if #(
    parameter int HANDLE_BITS = tsd_pkg::HANDLE_BITS,
    parameter int CNT_BITS    = $clog2(tsd_pkg::MAX_SUBS + 1)
);
    logic                         valid;
    logic                         ready;
    logic [tsd_pkg::STATUS_W-1:0] status;
    logic                         sub_valid;
    logic [HANDLE_BITS-1:0]       sub_handle;
    logic                         is_last;
    logic [tsd_pkg::TIME_W-1:0]   now_time;
    logic [CNT_BITS-1:0]          sub_count;

    modport source (output valid, output status, output sub_valid, output sub_handle,
                    output is_last, output now_time, output sub_count, input ready);
    modport sink (input valid, input status, input sub_valid, input sub_handle,
                  input is_last, input now_time, input sub_count, output ready);
endinterface

FILE: sv/tsd_ram.sv
module tsd_ram #(
    parameter int WIDTH = tsd_pkg::HANDLE_BITS,
    parameter int DEPTH = tsd_pkg::MAX_SUBS
) (
    input  logic                                 clk,
    input  logic                                 we,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr,
    input  logic [WIDTH-1:0]                     wdata,
    input  logic                                 re,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr,
    output logic [WIDTH-1:0]                     rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    // Read data holds its value while no read is issued.
    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        if (re)
        begin
            rdata_reg <= mem[raddr];
        end
    end

    assign rdata = rdata_reg;

endmodule

FILE: sv/tsd_vclk.sv
module tsd_vclk (
    input  logic                            clk,
    input  logic                            rst_n,
    input  logic                            cfg_we,
    input  logic [tsd_pkg::CFG_IDX_W-1:0]   cfg_index,
    input  logic [tsd_pkg::CFG_W-1:0]       cfg_data,
    input  tsd_pkg::tsd_tick_cmd_t          tick_cmd,
    output logic [tsd_pkg::TIME_W-1:0]      now_time
);

    localparam int TW = tsd_pkg::TIME_W;
    localparam int CW = tsd_pkg::CFG_W;

    logic [CW-1:0] period_reg;
    logic [CW-1:0] catchup_reg;
    logic [TW-1:0] clock_reg;
    logic [TW-1:0] prev_reg;
    logic          primed_reg;
    logic [CW-1:0] step_reg;
    logic          pend_reg;

    logic [TW-1:0] wall_delta;
    logic [CW-1:0] clamped_step;

    // Wrapping difference, limited to the catch-up bound.
    assign wall_delta   = tick_cmd.wall - prev_reg;
    assign clamped_step = (wall_delta > TW'(catchup_reg)) ? catchup_reg
                                                          : wall_delta[CW-1:0];

    // The step is registered at acceptance and added to the clock in the next cycle.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            period_reg  <= tsd_pkg::PERIOD_RST;
            catchup_reg <= tsd_pkg::CATCHUP_RST;
            clock_reg   <= '0;
            prev_reg    <= '0;
            primed_reg  <= 1'b0;
            step_reg    <= '0;
            pend_reg    <= 1'b0;
        end
        else
        begin
            pend_reg <= tick_cmd.go && (tick_cmd.nominal || tick_cmd.timed);
            if (pend_reg)
            begin
                clock_reg <= clock_reg + TW'(step_reg);
            end
            if (cfg_we)
            begin
                case (cfg_index)
                    tsd_pkg::CFG_TICK_PERIOD: period_reg  <= cfg_data;
                    tsd_pkg::CFG_MAX_CATCHUP: catchup_reg <= cfg_data;
                    default: ;
                endcase
            end
            if (tick_cmd.go)
            begin
                if (tick_cmd.clear)
                begin
                    clock_reg  <= '0;
                    prev_reg   <= '0;
                    primed_reg <= 1'b0;
                    period_reg <= tsd_pkg::PERIOD_RST;
                end
                else if (tick_cmd.nominal)
                begin
                    step_reg <= period_reg;
                end
                else if (tick_cmd.timed)
                begin
                    step_reg   <= primed_reg ? clamped_step : period_reg;
                    primed_reg <= 1'b1;
                    prev_reg   <= tick_cmd.wall;
                end
            end
        end
    end

    assign now_time = clock_reg;

endmodule

FILE: sv/tsd_seq.sv
module tsd_seq #(
    parameter int MAX_SUBS    = tsd_pkg::MAX_SUBS,
    parameter int HANDLE_BITS = tsd_pkg::HANDLE_BITS
) (
    input  logic                                       clk,
    input  logic                                       rst_n,
    tsd_in_if.sink                                     req,
    tsd_out_if.source                                  rsp,
    output tsd_pkg::tsd_tick_cmd_t                     tick_cmd,
    input  logic [tsd_pkg::TIME_W-1:0]                 now_time,
    output logic                                       mem_re,
    output logic [((MAX_SUBS > 1) ? $clog2(MAX_SUBS) : 1)-1:0] mem_raddr,
    input  logic [HANDLE_BITS-1:0]                     mem_rdata,
    output logic                                       mem_we,
    output logic [((MAX_SUBS > 1) ? $clog2(MAX_SUBS) : 1)-1:0] mem_waddr,
    output logic [HANDLE_BITS-1:0]                     mem_wdata
);

    localparam int IW = (MAX_SUBS > 1) ? $clog2(MAX_SUBS) : 1;
    localparam int CW = $clog2(MAX_SUBS + 1);
    localparam int TW = tsd_pkg::TIME_W;
    localparam int SW = tsd_pkg::STATUS_W;

    typedef enum logic [2:0] {S_IDLE, S_DISP, S_SCAN, S_SHIFT, S_FAN, S_FIN} state_t;

    state_t                     state_reg, state_next;
    logic [tsd_pkg::CMD_W-1:0]  cmd_reg, cmd_next;
    logic [HANDLE_BITS-1:0]     hnd_reg, hnd_next;
    logic [CW-1:0]              total_reg, total_next;
    logic [CW-1:0]              idx_reg, idx_next;
    logic                       rv_reg, rv_next;
    logic [IW-1:0]              ri_reg, ri_next;
    logic [SW-1:0]              status_reg, status_next;
    logic                       ov_reg, ov_next;
    logic [SW-1:0]              ostat_reg, ostat_next;
    logic                       osv_reg, osv_next;
    logic [HANDLE_BITS-1:0]     ohnd_reg, ohnd_next;
    logic                       olast_reg, olast_next;
    logic [TW-1:0]              onow_reg, onow_next;
    logic [CW-1:0]              ocnt_reg, ocnt_next;

    logic accept;
    logic out_free;
    logic in_range;
    logic issue;
    logic advance;
    logic out_load;
    logic hit;

    assign req.ready = (state_reg == S_IDLE);
    assign accept    = req.valid && req.ready;
    assign out_free  = !ov_reg || rsp.ready;
    assign in_range  = (idx_reg < total_reg);
    assign hit       = rv_reg && (mem_rdata == hnd_reg);

    always_comb
    begin
        state_next  = state_reg;
        cmd_next    = cmd_reg;
        hnd_next    = hnd_reg;
        total_next  = total_reg;
        idx_next    = idx_reg;
        rv_next     = rv_reg;
        ri_next     = ri_reg;
        status_next = status_reg;
        ov_next     = ov_reg && !rsp.ready;
        ostat_next  = ostat_reg;
        osv_next    = osv_reg;
        ohnd_next   = ohnd_reg;
        olast_next  = olast_reg;
        onow_next   = onow_reg;
        ocnt_next   = ocnt_reg;

        issue    = 1'b0;
        advance  = 1'b0;
        out_load = 1'b0;

        mem_re    = 1'b0;
        mem_raddr = idx_reg[IW-1:0];
        mem_we    = 1'b0;
        mem_waddr = total_reg[IW-1:0];
        mem_wdata = hnd_reg;

        tick_cmd         = '0;
        tick_cmd.wall    = req.wall_time;

        case (state_reg)
            S_IDLE:
            begin
                if (accept)
                begin
                    cmd_next         = req.cmd;
                    hnd_next         = req.handle;
                    state_next       = S_DISP;
                    tick_cmd.go      = 1'b1;
                    tick_cmd.nominal = (req.cmd == tsd_pkg::CMD_TICK);
                    tick_cmd.timed   = (req.cmd == tsd_pkg::CMD_TIMED);
                    tick_cmd.clear   = (req.cmd == tsd_pkg::CMD_RESET);
                end
            end

            S_DISP:
            begin
                idx_next    = '0;
                rv_next     = 1'b0;
                status_next = tsd_pkg::ST_OK;
                case (cmd_reg)
                    tsd_pkg::CMD_REG, tsd_pkg::CMD_UNREG:
                        state_next = S_SCAN;
                    tsd_pkg::CMD_TICK, tsd_pkg::CMD_TIMED:
                        state_next = (total_reg == '0) ? S_FIN : S_FAN;
                    tsd_pkg::CMD_RESET:
                    begin
                        total_next = '0;
                        state_next = S_FIN;
                    end
                    default:
                        state_next = S_FIN;
                endcase
            end

            // One entry is read per cycle; its compare lands in the next cycle.
            S_SCAN:
            begin
                issue   = in_range;
                mem_re  = issue;
                rv_next = issue;
                ri_next = idx_reg[IW-1:0];
                if (issue)
                begin
                    idx_next = idx_reg + CW'(1);
                end
                if (hit)
                begin
                    if (cmd_reg == tsd_pkg::CMD_REG)
                    begin
                        status_next = tsd_pkg::ST_OK;
                        state_next  = S_FIN;
                    end
                    else
                    begin
                        idx_next   = CW'(ri_reg) + CW'(1);
                        rv_next    = 1'b0;
                        state_next = S_SHIFT;
                    end
                end
                else if (!rv_reg && !issue)
                begin
                    state_next = S_FIN;
                    if (cmd_reg == tsd_pkg::CMD_REG)
                    begin
                        if (total_reg >= CW'(MAX_SUBS))
                        begin
                            status_next = tsd_pkg::ST_FULL;
                        end
                        else
                        begin
                            mem_we      = 1'b1;
                            total_next  = total_reg + CW'(1);
                            status_next = tsd_pkg::ST_OK;
                        end
                    end
                    else
                    begin
                        status_next = tsd_pkg::ST_MISSING;
                    end
                end
            end

            // Each entry after the removed one is read and written one place down.
            S_SHIFT:
            begin
                issue   = in_range;
                mem_re  = issue;
                rv_next = issue;
                ri_next = idx_reg[IW-1:0];
                if (issue)
                begin
                    idx_next = idx_reg + CW'(1);
                end
                if (rv_reg)
                begin
                    mem_we    = 1'b1;
                    mem_waddr = ri_reg - IW'(1);
                    mem_wdata = mem_rdata;
                end
                if (!rv_reg && !issue)
                begin
                    total_next  = total_reg - CW'(1);
                    status_next = tsd_pkg::ST_OK;
                    state_next  = S_FIN;
                end
            end

            // The read pipeline advances when no entry is pending or when the output
            // register takes the pending entry; the RAM holds its read data meanwhile.
            S_FAN:
            begin
                out_load = rv_reg && out_free;
                advance  = !rv_reg || out_load;
                issue    = advance && in_range;
                mem_re   = issue;
                if (issue)
                begin
                    idx_next = idx_reg + CW'(1);
                end
                if (advance)
                begin
                    rv_next = issue;
                    ri_next = idx_reg[IW-1:0];
                end
                if (out_load)
                begin
                    ov_next    = 1'b1;
                    ostat_next = tsd_pkg::ST_OK;
                    osv_next   = 1'b1;
                    ohnd_next  = mem_rdata;
                    olast_next = ((CW'(ri_reg) + CW'(1)) == total_reg);
                    onow_next  = now_time;
                    ocnt_next  = total_reg;
                end
                if (advance && !issue)
                begin
                    state_next = S_IDLE;
                end
            end

            S_FIN:
            begin
                if (out_free)
                begin
                    ov_next    = 1'b1;
                    ostat_next = status_reg;
                    osv_next   = 1'b0;
                    ohnd_next  = '0;
                    olast_next = 1'b1;
                    onow_next  = now_time;
                    ocnt_next  = total_reg;
                    state_next = S_IDLE;
                end
            end

            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg  <= S_IDLE;
            cmd_reg    <= '0;
            hnd_reg    <= '0;
            total_reg  <= '0;
            idx_reg    <= '0;
            rv_reg     <= 1'b0;
            ri_reg     <= '0;
            status_reg <= '0;
            ov_reg     <= 1'b0;
            ostat_reg  <= '0;
            osv_reg    <= 1'b0;
            ohnd_reg   <= '0;
            olast_reg  <= 1'b0;
            onow_reg   <= '0;
            ocnt_reg   <= '0;
        end
        else
        begin
            state_reg  <= state_next;
            cmd_reg    <= cmd_next;
            hnd_reg    <= hnd_next;
            total_reg  <= total_next;
            idx_reg    <= idx_next;
            rv_reg     <= rv_next;
            ri_reg     <= ri_next;
            status_reg <= status_next;
            ov_reg     <= ov_next;
            ostat_reg  <= ostat_next;
            osv_reg    <= osv_next;
            ohnd_reg   <= ohnd_next;
            olast_reg  <= olast_next;
            onow_reg   <= onow_next;
            ocnt_reg   <= ocnt_next;
        end
    end

    assign rsp.valid      = ov_reg;
    assign rsp.status     = ostat_reg;
    assign rsp.sub_valid  = osv_reg;
    assign rsp.sub_handle = ohnd_reg;
    assign rsp.is_last    = olast_reg;
    assign rsp.now_time   = onow_reg;
    assign rsp.sub_count  = ocnt_reg;

endmodule

FILE: sv/tick_subscriber_dispatch_unit.sv
// One item at a time. For a table of N handles, register does at most one RAM read per
// entry before its result transfer, and unregister also moves the later entries down
// one place behind the reads. A tick makes one transfer per subscriber, paced by the
// single table read port. Output stalls hold back the transfers of any item.
// Reset is asynchronous and active low; the table RAM needs no clearing pass.
`include "tick_subscriber_dispatch_unit_defines.svh"

module tick_subscriber_dispatch_unit #(
    parameter int MAX_SUBS    = tsd_pkg::MAX_SUBS,
    parameter int HANDLE_BITS = tsd_pkg::HANDLE_BITS
) (
    input  logic                          clk,
    input  logic                          rst_n,
    tsd_in_if.sink                        req,
    tsd_out_if.source                     rsp,
    input  logic                          cfg_we,
    input  logic [tsd_pkg::CFG_IDX_W-1:0] cfg_index,
    input  logic [tsd_pkg::CFG_W-1:0]     cfg_data
);

    localparam int IW = (MAX_SUBS > 1) ? $clog2(MAX_SUBS) : 1;
    localparam int CW = $clog2(MAX_SUBS + 1);

    tsd_pkg::tsd_tick_cmd_t        tick_cmd;
    logic [tsd_pkg::TIME_W-1:0]    now_time;
    logic                          mem_re;
    logic [IW-1:0]                 mem_raddr;
    logic [HANDLE_BITS-1:0]        mem_rdata;
    logic                          mem_we;
    logic [IW-1:0]                 mem_waddr;
    logic [HANDLE_BITS-1:0]        mem_wdata;

    tsd_ram #(
        .WIDTH (HANDLE_BITS),
        .DEPTH (MAX_SUBS)
    ) u_table (
        .clk   (clk),
        .we    (mem_we),
        .waddr (mem_waddr),
        .wdata (mem_wdata),
        .re    (mem_re),
        .raddr (mem_raddr),
        .rdata (mem_rdata)
    );

    tsd_vclk u_vclk (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .tick_cmd  (tick_cmd),
        .now_time  (now_time)
    );

    tsd_seq #(
        .MAX_SUBS    (MAX_SUBS),
        .HANDLE_BITS (HANDLE_BITS)
    ) u_seq (
        .clk       (clk),
        .rst_n     (rst_n),
        .req       (req),
        .rsp       (rsp),
        .tick_cmd  (tick_cmd),
        .now_time  (now_time),
        .mem_re    (mem_re),
        .mem_raddr (mem_raddr),
        .mem_rdata (mem_rdata),
        .mem_we    (mem_we),
        .mem_waddr (mem_waddr),
        .mem_wdata (mem_wdata)
    );

    // The sequencer is busy in the cycle after taking an item.
    `TSD_ASSERT(a_busy_after_accept, req.valid && req.ready |=> !req.ready)
    // A result that names no subscriber always closes its item.
    `TSD_ASSERT(a_single_is_last, rsp.valid && !rsp.sub_valid |-> rsp.is_last)
    // A fired subscriber implies a non-empty table and an ok status.
    `TSD_NEVER(a_fire_empty, rsp.valid && rsp.sub_valid && (rsp.sub_count == '0))
    `TSD_NEVER(a_fire_status, rsp.valid && rsp.sub_valid && (rsp.status != tsd_pkg::ST_OK))
    `TSD_NEVER(a_count_range, rsp.valid && (rsp.sub_count > CW'(MAX_SUBS)))

endmodule
